>>> rtl/cpm_pkg.sv
package cpm_pkg;

   localparam int CAPACITY_DEF        = 16;
   localparam int RESERVED_DEF        = 4;
   localparam int NORMAL_CAPACITY_DEF = 12;

   typedef enum logic [2:0] {
      ST_NORMAL    = 3'd0,
      ST_HIGH      = 3'd1,
      ST_COALESCED = 3'd2,
      ST_OVERFLOW  = 3'd3,
      ST_DROPPED   = 3'd4,
      ST_RECEIVED  = 3'd5,
      ST_EMPTY     = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_APPEND,
      S_RECV
   } state_type;

   typedef struct packed {
      logic        command;
      logic        is_command_msg;
      logic        is_critical;
      logic [7:0]  event_type;
      logic [15:0] msg_key;
      logic [31:0] payload;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic        out_is_command;
      logic        out_critical;
      logic [7:0]  out_event_type;
      logic [15:0] out_key;
      logic [31:0] out_payload;
      logic [4:0]  queued;
      logic [31:0] drops;
      logic [31:0] overflows;
   } rsp_type;

   // one queue slot
   typedef struct packed {
      logic        is_command_msg;
      logic        is_critical;
      logic [7:0]  event_type;
      logic [15:0] msg_key;
      logic [31:0] payload;
   } entry_type;

endpackage

>>> rtl/coalescing_priority_mailbox.sv
// Coalescing priority mailbox: a ring queue of CAPACITY messages held in one
// synchronous memory. Issue an item with start while busy is low; exactly one
// result follows, shown for a single cycle with rsp_valid, and it cannot be
// held off. A receive on an empty queue is answered from idle, so busy stays
// low and the next item may start at once; any other receive makes one
// memory read of the head slot. A post of a command, of an event with key 0,
// or into an empty queue goes straight to the append step. Any other post
// reads the queued slots one per cycle from head toward tail looking for an
// event with the same type and key, as the memory has a single read port.
// A match stops the scan early and overwrites that slot. The queued result
// field carries the low 5 bits of the fill count; drops and overflows wrap
// at 32 bits.
module coalescing_priority_mailbox #(
   parameter int CAPACITY        = cpm_pkg::CAPACITY_DEF,
   parameter int RESERVED        = cpm_pkg::RESERVED_DEF,
   parameter int NORMAL_CAPACITY = cpm_pkg::NORMAL_CAPACITY_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  cpm_pkg::req_type req_data,
   output logic             rsp_valid,
   output cpm_pkg::rsp_type rsp_data
);

   localparam int PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(CAPACITY - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

   // message store, one read and one write port
   cpm_pkg::entry_type mem [CAPACITY];
   cpm_pkg::entry_type rd_data_ff;
   logic               rd_en;
   logic [PTR_W-1:0]   rd_addr;
   logic               wr_en;
   logic [PTR_W-1:0]   wr_addr;
   cpm_pkg::entry_type wr_data;

   cpm_pkg::state_type state_ff, state_in;

   // latched request
   cpm_pkg::req_type req_ff, req_in;

   // queue control
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [31:0]      drops_ff, drops_in;
   logic [31:0]      overflows_ff, overflows_in;

   // scan walk: next slot to read, reads issued, and whether the slot whose
   // data arrives now is the last queued one
   logic [PTR_W-1:0] scan_ptr_ff, scan_ptr_in;
   logic [PTR_W-1:0] cmp_ptr_ff, cmp_ptr_in;
   logic [CNT_W-1:0] issued_ff, issued_in;
   logic             last_ff, last_in;

   logic             rsp_valid_ff, rsp_valid_in;
   cpm_pkg::rsp_type rsp_ff, rsp_in;

   logic               accept;
   logic               wants_scan;
   logic               match;
   logic               no_room;
   logic               is_minor;
   cpm_pkg::entry_type new_entry;

   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
      ring_next = (p == LAST_PTR) ? '0 : p + PTR_W'(1);
   endfunction

   assign busy      = (state_ff != cpm_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign accept    = start && !busy;

   assign new_entry = '{
      is_command_msg: req_ff.is_command_msg,
      is_critical:    req_ff.is_critical,
      event_type:     req_ff.event_type,
      msg_key:        req_ff.msg_key,
      payload:        req_ff.payload
   };

   // only events with a nonzero key look for a queued twin
   assign wants_scan = !req_data.is_command_msg && (req_data.msg_key != '0)
                       && (fill_ff != '0);

   assign match = !rd_data_ff.is_command_msg
                  && (rd_data_ff.event_type == req_ff.event_type)
                  && (rd_data_ff.msg_key == req_ff.msg_key);

   // free slots at or below the reserve
   assign no_room  = (32'(fill_ff) + 32'(RESERVED)) >= 32'(CAPACITY);
   assign is_minor = !req_ff.is_command_msg && !req_ff.is_critical;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cpm_pkg::S_IDLE: begin
            if (accept) begin
               if (req_data.command) begin
                  if (fill_ff != '0) begin
                     state_in = cpm_pkg::S_RECV;
                  end
               end else if (wants_scan) begin
                  state_in = cpm_pkg::S_SCAN;
               end else begin
                  state_in = cpm_pkg::S_APPEND;
               end
            end
         end
         cpm_pkg::S_SCAN: begin
            if (match) begin
               state_in = cpm_pkg::S_IDLE;
            end else if (last_ff) begin
               state_in = cpm_pkg::S_APPEND;
            end
         end
         cpm_pkg::S_APPEND: state_in = cpm_pkg::S_IDLE;
         cpm_pkg::S_RECV:   state_in = cpm_pkg::S_IDLE;
         default:           state_in = cpm_pkg::S_IDLE;
      endcase
   end

   // datapath, memory ports and result
   always_comb begin
      req_in       = req_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      fill_in      = fill_ff;
      drops_in     = drops_ff;
      overflows_in = overflows_ff;
      scan_ptr_in  = scan_ptr_ff;
      cmp_ptr_in   = cmp_ptr_ff;
      issued_in    = issued_ff;
      last_in      = last_ff;
      rd_en        = 1'b0;
      rd_addr      = head_ff;
      wr_en        = 1'b0;
      wr_addr      = tail_ff;
      wr_data      = new_entry;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      rsp_in.status = cpm_pkg::ST_NORMAL;

      unique case (state_ff)
         cpm_pkg::S_IDLE: begin
            if (accept) begin
               req_in = req_data;
               if (req_data.command && (fill_ff == '0)) begin
                  // empty receive answers at once
                  rsp_valid_in = 1'b1;
                  rsp_in.status = cpm_pkg::ST_EMPTY;
               end else if (req_data.command || wants_scan) begin
                  // head read serves both a receive and the first scan step
                  rd_en       = 1'b1;
                  rd_addr     = head_ff;
                  cmp_ptr_in  = head_ff;
                  scan_ptr_in = ring_next(head_ff);
                  issued_in   = CNT_W'(1);
                  last_in     = (fill_ff == CNT_W'(1));
               end
            end
         end
         cpm_pkg::S_SCAN: begin
            if (match) begin
               wr_en         = 1'b1;
               wr_addr       = cmp_ptr_ff;
               rsp_valid_in  = 1'b1;
               rsp_in.status = cpm_pkg::ST_COALESCED;
            end else if (!last_ff) begin
               rd_en       = 1'b1;
               rd_addr     = scan_ptr_ff;
               cmp_ptr_in  = scan_ptr_ff;
               scan_ptr_in = ring_next(scan_ptr_ff);
               issued_in   = issued_ff + CNT_W'(1);
               last_in     = ((issued_ff + CNT_W'(1)) == fill_ff);
            end
         end
         cpm_pkg::S_APPEND: begin
            rsp_valid_in = 1'b1;
            if (fill_ff == FULL_CNT) begin
               overflows_in  = overflows_ff + 32'd1;
               drops_in      = drops_ff + 32'd1;
               rsp_in.status = cpm_pkg::ST_OVERFLOW;
            end else if (is_minor && no_room) begin
               drops_in      = drops_ff + 32'd1;
               rsp_in.status = cpm_pkg::ST_DROPPED;
            end else begin
               wr_en   = 1'b1;
               wr_addr = tail_ff;
               tail_in = ring_next(tail_ff);
               fill_in = fill_ff + CNT_W'(1);
               rsp_in.status = (32'(fill_ff) < 32'(NORMAL_CAPACITY)) ?
                               cpm_pkg::ST_NORMAL : cpm_pkg::ST_HIGH;
            end
         end
         cpm_pkg::S_RECV: begin
            rsp_valid_in          = 1'b1;
            rsp_in.status         = cpm_pkg::ST_RECEIVED;
            rsp_in.out_is_command = rd_data_ff.is_command_msg;
            rsp_in.out_critical   = rd_data_ff.is_critical;
            rsp_in.out_event_type = rd_data_ff.event_type;
            rsp_in.out_key        = rd_data_ff.msg_key;
            rsp_in.out_payload    = rd_data_ff.payload;
            head_in = ring_next(head_ff);
            fill_in = fill_ff - CNT_W'(1);
         end
         default: begin
         end
      endcase

      rsp_in.queued    = 5'(fill_in);
      rsp_in.drops     = drops_in;
      rsp_in.overflows = overflows_in;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cpm_pkg::S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         fill_ff      <= '0;
         drops_ff     <= '0;
         overflows_ff <= '0;
         issued_ff    <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fill_ff      <= fill_in;
         drops_ff     <= drops_in;
         overflows_ff <= overflows_in;
         issued_ff    <= issued_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      scan_ptr_ff <= scan_ptr_in;
      cmp_ptr_ff  <= cmp_ptr_in;
      rsp_ff      <= rsp_in;
   end

   // slot memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule
